[design/min_stk_pkg.sv]
`default_nettype none

package min_stk_pkg;

  // fixed field widths of the item formats
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  typedef logic [CMD_W-1:0]          cmd_t;
  typedef logic [STAT_W-1:0]         stat_t;
  typedef logic signed [DATA_W-1:0]  data_t;
  typedef logic [COUNT_W-1:0]        count_t;

  // command codes, anything else reads without change
  localparam cmd_t CMD_PUSH = 2'd0;
  localparam cmd_t CMD_POP  = 2'd1;

  // status codes
  localparam stat_t ST_OK        = 2'd0;
  localparam stat_t ST_UNDERFLOW = 2'd1;
  localparam stat_t ST_OVERFLOW  = 2'd2;

  typedef struct packed {
    cmd_t  command;
    data_t value;
  } in_item_t;

  typedef struct packed {
    stat_t  status;
    data_t  top_value;
    data_t  min_value;
    logic   is_empty;
    count_t entry_count;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic exec;   // accepted item, update counts and stores
    logic load;   // refill top registers from store read data
    logic emit;   // load the result register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_ok;    // accepted item is a pop of a non-empty stack
    logic out_busy;  // result register holds an item not yet taken
  } dp_stat_t;

endpackage

`default_nettype wire

[design/min_stk_ctrl.sv]
`default_nettype none

module min_stk_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire min_stk_pkg::dp_stat_t sts,
  output min_stk_pkg::dp_cmd_t       cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = sts.pop_ok ? S_LOAD : S_EMIT;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[design/min_stk_dp.sv]
`default_nettype none

module min_stk_dp #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire min_stk_pkg::in_item_t  in_data,
  input  wire min_stk_pkg::dp_cmd_t   cmd,
  output min_stk_pkg::dp_stat_t       sts,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output min_stk_pkg::out_item_t      out_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [CW-1:0] TWO_C   = CW'(2);

  // stores
  min_stk_pkg::data_t vmem [STACK_DEPTH];
  min_stk_pkg::data_t mmem [STACK_DEPTH];

  logic [CW-1:0]       vcount_r, vcount_nxt;
  logic [CW-1:0]       mcount_r, mcount_nxt;
  min_stk_pkg::data_t  top_r, top_nxt;
  min_stk_pkg::data_t  mtop_r, mtop_nxt;
  min_stk_pkg::stat_t  status_r, status_nxt;
  min_stk_pkg::data_t  vrd_r, mrd_r;
  logic                out_valid_r;
  min_stk_pkg::out_item_t out_r;

  logic          is_push, is_pop, push_ok, pop_ok, min_take, min_pop;
  logic          vwr_en, mwr_en, rd_en;
  logic [AW-1:0] vwr_addr, mwr_addr, vrd_addr, mrd_addr;
  logic [CW-1:0] vrd_cnt, mrd_cnt;

  // decode of the accepted item against the current tops
  always_comb begin
    is_push  = (in_data.command == min_stk_pkg::CMD_PUSH);
    is_pop   = (in_data.command == min_stk_pkg::CMD_POP);
    push_ok  = is_push && (vcount_r < DEPTH_C);
    pop_ok   = is_pop && (vcount_r != '0);
    min_take = ((mcount_r == '0) || (in_data.value <= mtop_r)) && (mcount_r < DEPTH_C);
    min_pop  = (mcount_r != '0) && (mtop_r == top_r);
  end

  assign sts.pop_ok   = pop_ok;
  assign sts.out_busy = out_valid_r && !out_ready;

  // store ports
  always_comb begin
    vwr_en   = cmd.exec && push_ok;
    mwr_en   = cmd.exec && push_ok && min_take;
    rd_en    = cmd.exec && pop_ok;
    vwr_addr = vcount_r[AW-1:0];
    mwr_addr = mcount_r[AW-1:0];
    // new tops after a pop sit one below the new counts
    vrd_cnt  = vcount_r - TWO_C;
    mrd_cnt  = min_pop ? (mcount_r - TWO_C) : (mcount_r - ONE_C);
    vrd_addr = vrd_cnt[AW-1:0];
    mrd_addr = mrd_cnt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (vwr_en) begin
      vmem[vwr_addr] <= in_data.value;
    end
    if (rd_en) begin
      vrd_r <= vmem[vrd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mwr_en) begin
      mmem[mwr_addr] <= in_data.value;
    end
    if (rd_en) begin
      mrd_r <= mmem[mrd_addr];
    end
  end

  // counts, cached tops and status
  always_comb begin
    vcount_nxt = vcount_r;
    mcount_nxt = mcount_r;
    top_nxt    = top_r;
    mtop_nxt   = mtop_r;
    status_nxt = status_r;
    if (cmd.exec) begin
      status_nxt = min_stk_pkg::ST_OK;
      if (is_push) begin
        if (push_ok) begin
          vcount_nxt = vcount_r + ONE_C;
          top_nxt    = in_data.value;
          if (min_take) begin
            mcount_nxt = mcount_r + ONE_C;
            mtop_nxt   = in_data.value;
          end
        end else begin
          status_nxt = min_stk_pkg::ST_OVERFLOW;
        end
      end else if (is_pop) begin
        if (pop_ok) begin
          vcount_nxt = vcount_r - ONE_C;
          if (min_pop) begin
            mcount_nxt = mcount_r - ONE_C;
          end
        end else begin
          status_nxt = min_stk_pkg::ST_UNDERFLOW;
        end
      end
    end else if (cmd.load) begin
      top_nxt  = vrd_r;
      mtop_nxt = mrd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
      mcount_r <= '0;
    end else begin
      vcount_r <= vcount_nxt;
      mcount_r <= mcount_nxt;
    end
    top_r    <= top_nxt;
    mtop_r   <= mtop_nxt;
    status_r <= status_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_r.status      <= status_r;
      out_r.top_value   <= (vcount_r != '0) ? top_r : '0;
      out_r.min_value   <= ((vcount_r != '0) && (mcount_r != '0)) ? mtop_r : '0;
      out_r.is_empty    <= (vcount_r == '0);
      out_r.entry_count <= min_stk_pkg::count_t'(vcount_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[design/min_tracking_stack_top.sv]
`default_nettype none

// channel  | valid     | ready     | payload
// ---------+-----------+-----------+---------------------------------------------
// input    | in_valid  | in_ready  | in_data  (command, value)
// result   | out_valid | out_ready | out_data (status, top, min, empty, count)
//
// push and read items go through idle and emit; a pop of a non-empty stack
// also passes load, the registered read of both stores for the new tops.
// one item is in work at a time; the next is taken once its result sits in
// the output register, even while that result is still waiting.
// reset (rst_n low, synchronous) empties the stack; store contents are kept.
// a stalled result register holds the controller until out_ready.

module min_tracking_stack_top #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire min_stk_pkg::in_item_t  in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output min_stk_pkg::out_item_t      out_data
);

  min_stk_pkg::dp_cmd_t  cmd;
  min_stk_pkg::dp_stat_t sts;

  min_stk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  min_stk_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
